@@ sv/tfr_pkg.sv @@
// tfr_pkg: shared types and constants for the telemetry frame receiver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package tfr_pkg;

    localparam int FRAME_BYTES = 20;
    localparam int POS_W       = 5;
    localparam int TDATA_W     = 128;

    typedef enum logic [1:0] {
        KIND_GOOD       = 2'd0,
        KIND_FRAME_ERR  = 2'd1,
        KIND_CSUM_ERR   = 2'd2,
        KIND_DISCONNECT = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_START_MARKER = 2'd0,
        CFG_FRAME_ID     = 2'd1,
        CFG_END_MARKER   = 2'd2,
        CFG_TIMEOUT_MS   = 2'd3
    } t_cfg_idx;

    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
    localparam logic [15:0] QUIET_MAX     = 16'hFFFF;
    localparam logic signed [15:0] BATT_MAX = 16'sd1000;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_CSUM_END = POS_W'(17);

    // completed frame handed from the collector to the link logic
    typedef struct packed {
        logic                             done;
        t_kind                            kind;
        logic [FRAME_BYTES-1:0][7:0]      bytes;   // index k = frame byte k
    } t_frame;

    // decoded fields, first member lands in the highest bits
    typedef struct packed {
        logic              link_up;
        logic [2:0]        status_bits;
        logic [7:0]        winding_temp;
        logic [7:0]        switch_temp;
        logic [7:0]        fault_value;
        logic signed [19:0] electrical_rpm;
        logic signed [15:0] supply_amps_tenths;
        logic signed [15:0] motor_amps_tenths;
        logic signed [15:0] voltage_tenths;
        logic [9:0]        battery_tenths;
        logic [14:0]       road_speed;
        t_kind             result_kind;
    } t_result;

    // result bits above the kind, carried on tdata
    localparam int RESULT_DATA_W = $bits(t_result) - $bits(t_kind);

endpackage

@@ sv/tfr_frame_collect.sv @@
// tfr_frame_collect: start-byte hunt, 20-byte window, running XOR and frame check.
// Depends on tfr_pkg.
`timescale 1ns / 1ps
module tfr_frame_collect
    import tfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_byte_step,     // a byte word is consumed this cycle
    input  logic [7:0]  i_byte,
    input  logic [7:0]  i_start_marker,
    input  logic [7:0]  i_frame_id,
    input  logic [7:0]  i_end_marker,
    output t_frame      o_frame
);

    logic                         r_hunting, n_hunting;
    logic [POS_W-1:0]             r_pos, n_pos;
    logic [7:0]                   r_xor, n_xor;
    logic [FRAME_BYTES-2:0][7:0]  r_win, n_win;   // newest byte at index 0

    logic [FRAME_BYTES-1:0][7:0]  frame_bytes;
    logic                         frame_done;

    always_comb begin
        for (int k = 0; k < FRAME_BYTES - 1; k++) begin
            frame_bytes[k] = r_win[FRAME_BYTES - 2 - k];
        end
        frame_bytes[FRAME_BYTES-1] = i_byte;
    end

    assign frame_done = i_byte_step && !r_hunting && (r_pos == POS_LAST);

    always_comb begin
        n_hunting = r_hunting;
        n_pos     = r_pos;
        n_xor     = r_xor;
        n_win     = r_win;
        if (i_byte_step) begin
            if (r_hunting) begin
                if (i_byte == i_start_marker) begin
                    n_hunting = 1'b0;
                    n_pos     = POS_W'(1);
                    n_xor     = '0;
                    n_win     = {r_win[FRAME_BYTES-3:0], i_byte};
                end
            end else if (r_pos == POS_LAST) begin
                n_hunting = 1'b1;
                n_pos     = '0;
            end else begin
                n_pos = r_pos + POS_W'(1);
                n_win = {r_win[FRAME_BYTES-3:0], i_byte};
                if (r_pos <= POS_CSUM_END) begin
                    n_xor = r_xor ^ i_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunting <= 1'b1;
            r_pos     <= '0;
            r_xor     <= '0;
        end else begin
            r_hunting <= n_hunting;
            r_pos     <= n_pos;
            r_xor     <= n_xor;
        end
        r_win <= n_win;
    end

    always_comb begin
        o_frame.done  = frame_done;
        o_frame.bytes = frame_bytes;
        if (frame_bytes[0] != i_start_marker || frame_bytes[1] != i_frame_id ||
            frame_bytes[FRAME_BYTES-1] != i_end_marker) begin
            o_frame.kind = KIND_FRAME_ERR;
        end else if (r_xor != frame_bytes[FRAME_BYTES-2]) begin
            o_frame.kind = KIND_CSUM_ERR;
        end else begin
            o_frame.kind = KIND_GOOD;
        end
    end

endmodule

@@ sv/tfr_link.sv @@
// tfr_link: field decode, last good record, quiet timer and connected flag.
// Depends on tfr_pkg; builds one result per frame or disconnect.
`timescale 1ns / 1ps
module tfr_link
    import tfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tick_step,     // a tick word is consumed this cycle
    input  t_frame      i_frame,
    input  logic [15:0] i_timeout_ms,
    output logic        o_res_valid,
    output t_result     o_res
);

    t_result            r_rec, n_rec;     // link_up and kind members unused
    logic [15:0]        r_quiet, n_quiet;
    logic               r_conn, n_conn;

    logic [15:0]        quiet_inc;
    t_result            dec;
    logic signed [15:0] spd_raw, bat_raw, erpm_raw;

    function automatic logic signed [15:0] be16(input logic [7:0] hi, input logic [7:0] lo);
        return {hi, lo};
    endfunction

    assign quiet_inc = (r_quiet < QUIET_MAX) ? r_quiet + 16'd1 : r_quiet;

    always_comb begin
        spd_raw  = be16(i_frame.bytes[2],  i_frame.bytes[3]);
        bat_raw  = be16(i_frame.bytes[4],  i_frame.bytes[5]);
        erpm_raw = be16(i_frame.bytes[12], i_frame.bytes[13]);
        dec = '0;
        dec.result_kind        = KIND_GOOD;
        dec.link_up            = 1'b1;
        dec.road_speed         = spd_raw[15] ? '0 : spd_raw[14:0];
        if (bat_raw[15]) begin
            dec.battery_tenths = '0;
        end else if (bat_raw > BATT_MAX) begin
            dec.battery_tenths = BATT_MAX[9:0];
        end else begin
            dec.battery_tenths = bat_raw[9:0];
        end
        dec.voltage_tenths     = be16(i_frame.bytes[6],  i_frame.bytes[7]);
        dec.motor_amps_tenths  = be16(i_frame.bytes[8],  i_frame.bytes[9]);
        dec.supply_amps_tenths = be16(i_frame.bytes[10], i_frame.bytes[11]);
        // x10 as x8 + x2
        dec.electrical_rpm     = (20'(erpm_raw) <<< 3) + (20'(erpm_raw) <<< 1);
        dec.fault_value        = i_frame.bytes[14];
        dec.switch_temp        = i_frame.bytes[15];
        dec.winding_temp       = i_frame.bytes[16];
        dec.status_bits        = i_frame.bytes[17][2:0];
    end

    always_comb begin
        n_rec       = r_rec;
        n_quiet     = r_quiet;
        n_conn      = r_conn;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.result_kind = KIND_GOOD;
        if (i_tick_step) begin
            n_quiet = quiet_inc;
            if (r_conn && quiet_inc > i_timeout_ms) begin
                n_conn            = 1'b0;
                o_res_valid       = 1'b1;
                o_res             = r_rec;
                o_res.result_kind = KIND_DISCONNECT;
                o_res.road_speed  = '0;
                o_res.link_up     = 1'b0;
            end
        end else if (i_frame.done) begin
            o_res_valid = 1'b1;
            if (i_frame.kind == KIND_GOOD) begin
                n_rec   = dec;
                n_conn  = 1'b1;
                n_quiet = '0;
                o_res   = dec;
            end else begin
                o_res.result_kind = i_frame.kind;
                o_res.link_up     = r_conn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec   <= '0;
            r_quiet <= '0;
            r_conn  <= 1'b0;
        end else begin
            r_rec   <= n_rec;
            r_quiet <= n_quiet;
            r_conn  <= n_conn;
        end
    end

endmodule

@@ sv/telemetry_frame_receiver.sv @@
// telemetry_frame_receiver: top level, input word register, config registers,
// result register. Depends on tfr_pkg, tfr_frame_collect, tfr_link.
//
//  channel    | direction | handshake             | payload
//  -----------+-----------+-----------------------+-------------------------------
//  s_axis     | in        | tvalid / tready       | tdata rx_data, tuser req_type
//  m_axis     | out       | tvalid / tready       | tdata decoded fields (128 bits),
//             |           |                       | tuser result_kind
//  cfg        | in        | we, no wait           | idx 0..3, wdata 16 bits
//
// One word per cycle sustained while m_axis does not stall. A word is held in the
// input register, then its result (if any) is registered in the output register,
// which drives tvalid. Synchronous active-low reset; no clearing pass,
// ready right after reset. A stalled output register holds the input register;
// s_axis tready drops only while the input register is full and m_axis is stalled.
`timescale 1ns / 1ps
module telemetry_frame_receiver
    import tfr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [7:0]         i_s_axis_tdata,   // [7:0] rx_data
    input  logic [0:0]         i_s_axis_tuser,   // [0] req_type
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // [14:0] road_speed, [24:15] battery_tenths, [40:25] voltage_tenths,
    // [56:41] motor_amps_tenths, [72:57] supply_amps_tenths, [92:73] electrical_rpm,
    // [100:93] fault_value, [108:101] switch_temp, [116:109] winding_temp,
    // [119:117] status_bits, [120] link_up, rest zero
    output logic [TDATA_W-1:0] o_m_axis_tdata,
    output logic [1:0]         o_m_axis_tuser,   // [1:0] result_kind
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_wdata
);

    logic [7:0]  r_start_marker, r_frame_id, r_end_marker;
    logic [15:0] r_timeout_ms;

    logic        r_in_valid;
    logic        r_in_tick;
    logic [7:0]  r_in_byte;

    logic        r_out_valid;
    t_result     r_out;

    logic        out_free;
    logic        step;
    t_frame      frame;
    logic        res_valid;
    t_result     res;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= '0;
            r_frame_id     <= '0;
            r_end_marker   <= '0;
            r_timeout_ms   <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_START_MARKER: r_start_marker <= i_cfg_wdata[7:0];
                CFG_FRAME_ID:     r_frame_id     <= i_cfg_wdata[7:0];
                CFG_END_MARKER:   r_end_marker   <= i_cfg_wdata[7:0];
                CFG_TIMEOUT_MS:   r_timeout_ms   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_tick <= i_s_axis_tuser[0];
            r_in_byte <= i_s_axis_tdata;
        end
    end

    tfr_frame_collect u_collect (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_byte_step    (step && !r_in_tick),
        .i_byte         (r_in_byte),
        .i_start_marker (r_start_marker),
        .i_frame_id     (r_frame_id),
        .i_end_marker   (r_end_marker),
        .o_frame        (frame)
    );

    tfr_link u_link (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_step  (step && r_in_tick),
        .i_frame      (frame),
        .i_timeout_ms (r_timeout_ms),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && res_valid;
        end
        if (out_free && step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.result_kind;
    assign o_m_axis_tdata  = {(TDATA_W - RESULT_DATA_W)'(0),
                              r_out[$bits(t_result)-1:$bits(t_kind)]};

endmodule

@@ dv/tfr_checker.sv @@
// tfr_checker: watches the input, result and register channels of the telemetry
// frame receiver, runs its own frame parser and compares every result word.
// Depends on tfr_pkg for the result layout, result kinds and register indexes.
`timescale 1ns / 1ps
module tfr_checker
    import tfr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_s_tready,
    input  logic [7:0]         i_s_tdata,
    input  logic [0:0]         i_s_tuser,
    input  logic               i_m_tvalid,
    input  logic               i_m_tready,
    input  logic [TDATA_W-1:0] i_m_tdata,
    input  logic [1:0]         i_m_tuser,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_wdata,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int REPORT_LIMIT = 10;
    localparam int BATTERY_CEIL = 1000;
    localparam int RPM_SCALE    = 10;
    localparam int CSUM_LAST    = 17;

    // register mirror
    logic [7:0]  start_marker;
    logic [7:0]  frame_id;
    logic [7:0]  end_marker;
    logic [15:0] timeout_ms;

    // parser state
    bit          hunting;
    int          byte_pos;
    logic [7:0]  frame_bytes [FRAME_BYTES];
    t_result     last_decoded;   // kind and link_up unused here
    logic [15:0] quiet_ms;
    bit          connected;

    t_result     telemetry_q [$];

    task automatic compare_field(string fname, logic [19:0] want, logic [19:0] got);
        if (got !== want) begin
            if (o_fail_count < REPORT_LIMIT)
                $display("tfr_checker: %0t %s expected %h got %h", $time, fname, want, got);
            o_fail_count++;
        end
    endtask

    task automatic compare_word();
        t_result got;
        t_result want;
        got = {i_m_tdata[RESULT_DATA_W-1:0], i_m_tuser};
        if (telemetry_q.size() == 0) begin
            if (o_fail_count < REPORT_LIMIT)
                $display("tfr_checker: %0t result word with none expected: %h / %h",
                         $time, i_m_tuser, i_m_tdata);
            o_fail_count++;
        end else begin
            want = telemetry_q.pop_front();
            compare_field("result_kind", want.result_kind, got.result_kind);
            compare_field("road_speed", want.road_speed, got.road_speed);
            compare_field("battery_tenths", want.battery_tenths, got.battery_tenths);
            compare_field("voltage_tenths", want.voltage_tenths, got.voltage_tenths);
            compare_field("motor_amps_tenths", want.motor_amps_tenths,
                          got.motor_amps_tenths);
            compare_field("supply_amps_tenths", want.supply_amps_tenths,
                          got.supply_amps_tenths);
            compare_field("electrical_rpm", want.electrical_rpm, got.electrical_rpm);
            compare_field("fault_value", want.fault_value, got.fault_value);
            compare_field("switch_temp", want.switch_temp, got.switch_temp);
            compare_field("winding_temp", want.winding_temp, got.winding_temp);
            compare_field("status_bits", want.status_bits, got.status_bits);
            compare_field("link_up", want.link_up, got.link_up);
            compare_field("upper pad", '0, i_m_tdata[TDATA_W-1:RESULT_DATA_W]);
        end
    endtask

    // advance the parser by one accepted word, queue the result it gives
    task automatic parse_word(bit is_tick, logic [7:0] rx_byte);
        t_result            res;
        t_kind              kind;
        logic [7:0]         csum;
        logic signed [15:0] s16;
        logic signed [19:0] rpm_wide;
        res = '0;
        if (is_tick) begin
            if (quiet_ms != 16'hFFFF)
                quiet_ms++;
            if (connected && quiet_ms > timeout_ms) begin
                connected = 0;
                res = last_decoded;
                res.result_kind = KIND_DISCONNECT;
                res.road_speed = '0;
                res.link_up = 1'b0;
                telemetry_q.push_back(res);
            end
        end else if (hunting) begin
            if (rx_byte == start_marker) begin
                frame_bytes[0] = rx_byte;
                byte_pos = 1;
                hunting = 0;
            end
        end else begin
            frame_bytes[byte_pos] = rx_byte;
            byte_pos++;
            if (byte_pos == FRAME_BYTES) begin
                byte_pos = 0;
                hunting = 1;
                csum = '0;
                for (int k = 1; k <= CSUM_LAST; k++)
                    csum ^= frame_bytes[k];
                if (frame_bytes[0] != start_marker || frame_bytes[1] != frame_id ||
                    frame_bytes[FRAME_BYTES-1] != end_marker)
                    kind = KIND_FRAME_ERR;
                else if (csum != frame_bytes[CSUM_LAST+1])
                    kind = KIND_CSUM_ERR;
                else
                    kind = KIND_GOOD;

                if (kind == KIND_GOOD) begin
                    s16 = {frame_bytes[2], frame_bytes[3]};
                    last_decoded.road_speed = (s16 < 0) ? '0 : s16[14:0];
                    s16 = {frame_bytes[4], frame_bytes[5]};
                    if (s16 < 0)
                        last_decoded.battery_tenths = '0;
                    else if (s16 > BATTERY_CEIL)
                        last_decoded.battery_tenths = 10'(BATTERY_CEIL);
                    else
                        last_decoded.battery_tenths = s16[9:0];
                    last_decoded.voltage_tenths     = {frame_bytes[6], frame_bytes[7]};
                    last_decoded.motor_amps_tenths  = {frame_bytes[8], frame_bytes[9]};
                    last_decoded.supply_amps_tenths = {frame_bytes[10], frame_bytes[11]};
                    s16 = {frame_bytes[12], frame_bytes[13]};
                    rpm_wide = s16;
                    last_decoded.electrical_rpm = 20'(rpm_wide * RPM_SCALE);
                    last_decoded.fault_value  = frame_bytes[14];
                    last_decoded.switch_temp  = frame_bytes[15];
                    last_decoded.winding_temp = frame_bytes[16];
                    last_decoded.status_bits  = frame_bytes[17][2:0];
                    connected = 1;
                    quiet_ms = '0;
                    res = last_decoded;
                    res.link_up = 1'b1;
                end else begin
                    res.link_up = connected;
                end
                res.result_kind = kind;
                telemetry_q.push_back(res);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_marker = '0;
            frame_id     = '0;
            end_marker   = '0;
            timeout_ms   = 16'd2000;
            hunting      = 1;
            byte_pos     = 0;
            last_decoded = '0;
            quiet_ms     = '0;
            connected    = 0;
            o_fail_count = 0;
            telemetry_q.delete();
        end else begin
            // results first: a word accepted now cannot have its result out yet
            if (i_m_tvalid && i_m_tready)
                compare_word();
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_START_MARKER: start_marker = i_cfg_wdata[7:0];
                    CFG_FRAME_ID:     frame_id     = i_cfg_wdata[7:0];
                    CFG_END_MARKER:   end_marker   = i_cfg_wdata[7:0];
                    CFG_TIMEOUT_MS:   timeout_ms   = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                parse_word(i_s_tuser[0], i_s_tdata);
        end
        o_pending = telemetry_q.size();
    end

endmodule

@@ dv/tb_telemetry_frame_receiver.sv @@
// tb_telemetry_frame_receiver: drives byte and tick words, register writes and
// result backpressure into telemetry_frame_receiver; tfr_checker does the checking.
// Depends on tfr_pkg, telemetry_frame_receiver and tfr_checker.
`timescale 1ns / 1ps
module tb_telemetry_frame_receiver;
    import tfr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int PHASE_WORDS    = 190;
    localparam int RANDOM_PHASES  = 8;
    localparam int CSUM_LAST      = 17;
    localparam int RESET_TICKS    = 40;

    typedef enum logic [2:0] {
        FR_GOOD,
        FR_BAD_ID,
        FR_BAD_END,
        FR_BAD_CSUM,
        FR_BAD_ID_CSUM
    } t_frame_shape;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_tdata = '0;
    logic [0:0]         s_tuser = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_idx = '0;
    logic [15:0]        cfg_wdata = '0;

    int fail_count;
    int pending;

    // stimulus-side copy of the markers, to build frames
    logic [7:0]  cur_start = '0;
    logic [7:0]  cur_id = '0;
    logic [7:0]  cur_end = '0;
    logic [15:0] cur_timeout = 16'd2000;
    logic [7:0]  frame_buf [FRAME_BYTES];
    bit          steady = 0;
    int          words_sent = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    telemetry_frame_receiver u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata)
    );

    tfr_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    // result side backpressure
    initial begin
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!steady && $urandom_range(0, 7) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(bit is_tick, logic [7:0] rx_byte);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_tdata <= rx_byte;
        s_tuser <= is_tick;
        do @(posedge clk); while (!s_ready);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_ticks(int count);
        repeat (count) send_word(1'b1, 8'($urandom));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_config(logic [7:0] sm, logic [7:0] pid, logic [7:0] em,
                              logic [15:0] tmo);
        cur_start = sm;
        cur_id = pid;
        cur_end = em;
        cur_timeout = tmo;
        // upper bits of the byte registers are don't-care, keep them moving
        cfg_we <= 1'b1;
        cfg_idx <= CFG_START_MARKER;
        cfg_wdata <= {8'($urandom), sm};
        @(negedge clk);
        cfg_idx <= CFG_FRAME_ID;
        cfg_wdata <= {8'($urandom), pid};
        @(negedge clk);
        cfg_idx <= CFG_END_MARKER;
        cfg_wdata <= {8'($urandom), em};
        @(negedge clk);
        cfg_idx <= CFG_TIMEOUT_MS;
        cfg_wdata <= tmo;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_body(logic [15:0] spd, logic [15:0] bat, logic [15:0] vlt,
                            logic [15:0] imot, logic [15:0] iin, logic [15:0] rpm,
                            logic [7:0] flt, logic [7:0] tsw, logic [7:0] twd,
                            logic [7:0] flg);
        {frame_buf[2], frame_buf[3]}   = spd;
        {frame_buf[4], frame_buf[5]}   = bat;
        {frame_buf[6], frame_buf[7]}   = vlt;
        {frame_buf[8], frame_buf[9]}   = imot;
        {frame_buf[10], frame_buf[11]} = iin;
        {frame_buf[12], frame_buf[13]} = rpm;
        frame_buf[14] = flt;
        frame_buf[15] = tsw;
        frame_buf[16] = twd;
        frame_buf[17] = flg;
    endtask

    task automatic fill_body();
        for (int k = 2; k <= CSUM_LAST; k++)
            frame_buf[k] = pick_byte();
        // keep battery near the clamp now and then
        if ($urandom_range(0, 3) == 0)
            {frame_buf[4], frame_buf[5]} = 16'($urandom_range(990, 1010));
    endtask

    task automatic send_frame(t_frame_shape shape, bit mix_ticks);
        logic [7:0] csum;
        frame_buf[0] = cur_start;
        frame_buf[1] = cur_id;
        if (shape == FR_BAD_ID || shape == FR_BAD_ID_CSUM)
            frame_buf[1] = cur_id ^ 8'($urandom_range(1, 255));
        csum = '0;
        for (int k = 1; k <= CSUM_LAST; k++)
            csum ^= frame_buf[k];
        frame_buf[CSUM_LAST+1] = csum;
        if (shape == FR_BAD_CSUM || shape == FR_BAD_ID_CSUM)
            frame_buf[CSUM_LAST+1] = csum ^ 8'($urandom_range(1, 255));
        frame_buf[FRAME_BYTES-1] = cur_end;
        if (shape == FR_BAD_END)
            frame_buf[FRAME_BYTES-1] = cur_end ^ 8'($urandom_range(1, 255));
        for (int k = 0; k < FRAME_BYTES; k++) begin
            // ticks inside a frame must not disturb the parser
            if (mix_ticks && $urandom_range(0, 11) == 0)
                send_word(1'b1, 8'($urandom));
            send_word(1'b0, frame_buf[k]);
        end
    endtask

    task automatic random_step();
        int r;
        int n;
        r = $urandom_range(0, 99);
        steady = ($urandom_range(0, 4) == 0);
        fill_body();
        if (r < 55) begin
            send_frame(FR_GOOD, 1'b1);
        end else if (r < 63) begin
            send_frame(FR_BAD_ID, 1'b1);
        end else if (r < 70) begin
            send_frame(FR_BAD_END, 1'b1);
        end else if (r < 78) begin
            send_frame(FR_BAD_CSUM, 1'b1);
        end else if (r < 82) begin
            send_frame(FR_BAD_ID_CSUM, 1'b1);
        end else if (r < 90) begin
            // line noise, sometimes a stray start byte that shifts the next frame
            n = $urandom_range(1, 6);
            repeat (n) begin
                if ($urandom_range(0, 2) == 0)
                    send_word(1'b0, cur_start);
                else
                    send_word(1'b0, 8'($urandom));
            end
        end else begin
            n = (cur_timeout < 30) ? int'(cur_timeout) + 3 : 30;
            send_ticks($urandom_range(1, n));
        end
    endtask

    // ends the run when no word moves on either channel for too long
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_telemetry_frame_receiver failed");
        $finish;
    end

    initial begin
        int phase_base;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset register values: all markers zero, default quiet timeout
        set_body(16'h0123, 16'h0200, 16'h01F4, 16'h0010, 16'hFFF0, 16'h0BB8,
                 8'h00, 8'h2A, 8'h33, 8'h05);
        send_frame(FR_GOOD, 1'b0);
        steady = 1;
        send_ticks(RESET_TICKS);   // well inside the default timeout
        steady = 0;
        wait_idle();

        // directed: field extremes and every error kind
        set_config(8'hA5, 8'h3C, 8'h5A, 16'd3);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'hFF);
        send_word(1'b0, 8'h5A);
        set_body(16'h7FFF, 16'h03E8, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h7FFF,
                 8'hFF, 8'h00, 8'hFF, 8'hFF);
        send_frame(FR_GOOD, 1'b0);
        set_body(16'h8000, 16'h03E9, 16'h8000, 16'h7FFF, 16'h0000, 16'h8000,
                 8'h00, 8'hFF, 8'h00, 8'hF8);
        send_frame(FR_GOOD, 1'b0);
        set_body(16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h8000, 16'hFFFF,
                 8'h80, 8'h7F, 8'h80, 8'h02);
        send_frame(FR_BAD_ID, 1'b0);
        send_frame(FR_BAD_END, 1'b0);
        send_frame(FR_BAD_CSUM, 1'b0);
        send_frame(FR_BAD_ID_CSUM, 1'b0);
        send_ticks(4);      // quiet time passes the timeout on the fourth
        send_ticks(3);
        send_frame(FR_BAD_END, 1'b0);
        send_frame(FR_GOOD, 1'b0);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: set_config(8'hA5, 8'h3C, 8'h5A, 16'd3);
                1: set_config(8'h00, 8'hFF, 8'hFF, 16'd0);
                2: set_config(8'hFF, 8'h00, 8'h00, 16'd1);
                3: set_config(8'h7E, 8'h7E, 8'h7E, 16'hFFFF);
                4: set_config(8'($urandom), 8'($urandom), 8'($urandom),
                              16'($urandom_range(2, 40)));
                5: set_config(8'($urandom), 8'($urandom), 8'($urandom),
                              16'($urandom_range(0, 10)));
                6: set_config(8'h55, 8'hAA, 8'h0F, 16'd20);
                default: set_config(8'($urandom), 8'($urandom), 8'($urandom),
                                    16'($urandom_range(0, 60)));
            endcase
            phase_base = words_sent;
            while (words_sent - phase_base < PHASE_WORDS)
                random_step();
            steady = 0;
            wait_idle();
        end

        if (fail_count == 0 && pending == 0)
            $display("tb_telemetry_frame_receiver passed");
        else
            $display("tb_telemetry_frame_receiver failed");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/tfr_pkg.sv
sv/tfr_frame_collect.sv
sv/tfr_link.sv
sv/telemetry_frame_receiver.sv
dv/tfr_checker.sv
dv/tb_telemetry_frame_receiver.sv
